FILE: rtl/rabs_pkg.sv
// Shared constants, register map and payload types of the background subtraction block.
`timescale 1ns / 1ps

package rabs_pkg;

  localparam int unsigned FRAME_WIDTH  = 640;
  localparam int unsigned FRAME_HEIGHT = 480;
  localparam int unsigned FRAME_SIZE   = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned ADDR_W       = $clog2(FRAME_SIZE);

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned THRESH_W   = 8;
  localparam int unsigned WARMUP_W   = 2;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = CFG_ADDR_W - 2;

  // Register indexes, taken from the word address of the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WARMUP    = 2'd2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 16'd852;
  localparam logic [THRESH_W-1:0] THRESHOLD_RST = 8'd150;
  localparam logic [WARMUP_W-1:0] WARMUP_RST    = 2'd2;
  localparam logic [WARMUP_W-1:0] FRAMES_MAX    = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } pix_in_t;

  typedef struct packed {
    logic             foreground;
    logic [PIX_W-1:0] difference;
    logic [PIX_W-1:0] background;
    logic             last_in_frame;
  } pix_out_t;

endpackage

FILE: rtl/running_average_background_subtract.sv
// Top level of the running-average background subtraction pipeline.
`timescale 1ns / 1ps

// Usage overview.
// Pixels enter in raster order on the input channel (in_valid_i, in_stall_o, in_data_i). A
// request is taken at a rising edge where in_valid_i is high and in_stall_o is low. The bit
// frame_end marks the last pixel of a frame and returns the pixel address to zero.
// During the warmup frames each pixel is only loaded into the background memory and gives
// no result. After that, every pixel gives one request on the output channel (out_valid_o,
// out_stall_i, out_data_o) with the updated background, the wrapped difference, the
// foreground flag and the frame-end copy.
// An accepted pixel goes through stages 1, 2 and 3 and the output register to out_valid_o.
// Throughput is one pixel per cycle when nothing stalls, set by the one read and one write
// per cycle of the background memory in a four-register pipeline. Two back-to-back blending
// pixels that share a memory entry (one-pixel frames) cost one bubble, because the second
// must wait for the first one's blend to reach the last stage before it can be forwarded.
// When the receiver stalls with a result waiting, the whole pipeline freezes and
// in_stall_o goes high; nothing is lost or repeated.
// Reset clears the pipeline valids, the pixel address, the frame counter and loads the
// register defaults. The background memory is not cleared: warmup fills it. The APB-style
// port holds weight (byte address 0x0), threshold (0x4) and warmup_frames (0x8). It is
// always ready. Write it only while the pipeline is idle; the block does not enforce it.
module running_average_background_subtract (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [rabs_pkg::CFG_ADDR_W-1:0]     paddr_i,
  input  logic [rabs_pkg::CFG_DATA_W-1:0]     pwdata_i,
  output logic [rabs_pkg::CFG_DATA_W-1:0]     prdata_o,
  output logic                                pready_o,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  rabs_pkg::pix_in_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output rabs_pkg::pix_out_t                  out_data_o
);
  import rabs_pkg::*;

  // Configuration registers.
  logic [WEIGHT_W-1:0]  weight_q;
  logic [THRESH_W-1:0]  threshold_q;
  logic [WARMUP_W-1:0]  warmup_q;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] reg_idx;

  // Stream position.
  logic [ADDR_W-1:0]   pixel_address_q, pixel_address_d;
  logic [WARMUP_W-1:0] frames_seen_q, frames_seen_d;
  logic [WARMUP_W-1:0] need;
  logic                s0_active;

  // Pipeline control.
  logic en;
  logic hold;
  logic accept;
  logic s1_load;
  logic mem_we;

  // Background memory and its registered read port.
  logic [PIX_W-1:0] bg_mem_q [FRAME_SIZE];
  logic [PIX_W-1:0] rdata_q;

  // The most recent write, for an item whose read was issued on the same edge.
  logic              lw_vld_q;
  logic [ADDR_W-1:0] lw_addr_q;
  logic [PIX_W-1:0]  lw_data_q;

  // Stage 1: memory data returns, forwarding, difference to the old background.
  logic              s1_vld_q;
  logic              s1_active_q;
  logic [PIX_W-1:0]  s1_pix_q;
  logic              s1_fend_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [PIX_W-1:0]  s1_old;
  logic signed [PIX_W:0] s1_delta;

  // Stage 2: weight times difference.
  logic                  s2_vld_q;
  logic                  s2_active_q;
  logic [PIX_W-1:0]      s2_pix_q;
  logic                  s2_fend_q;
  logic [ADDR_W-1:0]     s2_addr_q;
  logic [PIX_W-1:0]      s2_old_q;
  logic signed [PIX_W:0] s2_delta_q;
  logic signed [WEIGHT_W+PIX_W+1:0] s2_prod;

  // Stage 3: blend, difference, threshold and memory write.
  logic              s3_vld_q;
  logic              s3_active_q;
  logic [PIX_W-1:0]  s3_pix_q;
  logic              s3_fend_q;
  logic [ADDR_W-1:0] s3_addr_q;
  logic [PIX_W-1:0]  s3_old_q;
  logic [PIX_W-1:0]  s3_step_q;
  logic [PIX_W-1:0]  s3_bg;
  logic [PIX_W-1:0]  s3_diff;
  logic [PIX_W-1:0]  s3_wdata;

  // Output register.
  logic     out_valid_q;
  pix_out_t out_data_q;

  // ---------------------------------------------------------------------------
  // Configuration port.
  // ---------------------------------------------------------------------------
  assign pready_o = 1'b1;
  assign cfg_we   = psel_i & penable_i & pwrite_i & pready_o;
  assign reg_idx  = paddr_i[CFG_ADDR_W-1:2];

  always_comb begin
    prdata_o = '0;
    case (reg_idx)
      REG_WEIGHT:    prdata_o = {{(CFG_DATA_W-WEIGHT_W){1'b0}}, weight_q};
      REG_THRESHOLD: prdata_o = {{(CFG_DATA_W-THRESH_W){1'b0}}, threshold_q};
      REG_WARMUP:    prdata_o = {{(CFG_DATA_W-WARMUP_W){1'b0}}, warmup_q};
      default:       prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q    <= WEIGHT_RST;
      threshold_q <= THRESHOLD_RST;
      warmup_q    <= WARMUP_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_WEIGHT:    weight_q    <= pwdata_i[WEIGHT_W-1:0];
        REG_THRESHOLD: threshold_q <= pwdata_i[THRESH_W-1:0];
        REG_WARMUP:    warmup_q    <= pwdata_i[WARMUP_W-1:0];
        default:       ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control.
  // ---------------------------------------------------------------------------
  // The whole pipeline moves together unless a finished result is held by the receiver.
  assign en = !(out_valid_q && out_stall_i);

  // A blending item in stage 1 whose entry is still in stage 2 waits in stage 1;
  // stage 2 takes a bubble and the value is forwarded from stage 3 afterwards.
  assign hold = s1_vld_q && s1_active_q && s2_vld_q && (s2_addr_q == s1_addr_q);

  assign in_stall_o = !en || hold;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_load    = en && !hold;
  assign mem_we     = en && s3_vld_q;

  // A warmup register of zero behaves as one frame.
  assign need      = (warmup_q == '0) ? WARMUP_W'(1) : warmup_q;
  assign s0_active = (frames_seen_q >= need);

  always_comb begin
    pixel_address_d = pixel_address_q;
    frames_seen_d   = frames_seen_q;
    if (accept) begin
      if (in_data_i.frame_end) begin
        pixel_address_d = '0;
        if (frames_seen_q != FRAMES_MAX) begin
          frames_seen_d = frames_seen_q + WARMUP_W'(1);
        end
      end else if (pixel_address_q == ADDR_W'(FRAME_SIZE - 1)) begin
        pixel_address_d = '0;
      end else begin
        pixel_address_d = pixel_address_q + ADDR_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath.
  // ---------------------------------------------------------------------------
  // Forwarding order: stage 3 is newest, then the last write, then the memory.
  always_comb begin
    if (s3_vld_q && (s3_addr_q == s1_addr_q)) begin
      s1_old = s3_wdata;
    end else if (lw_vld_q && (lw_addr_q == s1_addr_q)) begin
      s1_old = lw_data_q;
    end else begin
      s1_old = rdata_q;
    end
  end

  assign s1_delta = $signed({1'b0, s1_pix_q}) - $signed({1'b0, s1_old});

  // old + floor(w * (pix - old) / 2^16) equals the Q0.16 blend with truncation.
  assign s2_prod = $signed({1'b0, weight_q}) * s2_delta_q;

  assign s3_bg    = s3_old_q + s3_step_q;
  assign s3_diff  = s3_pix_q - s3_bg;
  assign s3_wdata = s3_active_q ? s3_bg : s3_pix_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bg_mem_q[s3_addr_q] <= s3_wdata;
    end
    if (s1_load) begin
      rdata_q <= bg_mem_q[pixel_address_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_address_q <= '0;
      frames_seen_q   <= '0;
      s1_vld_q        <= 1'b0;
      s2_vld_q        <= 1'b0;
      s3_vld_q        <= 1'b0;
      out_valid_q     <= 1'b0;
      lw_vld_q        <= 1'b0;
    end else begin
      pixel_address_q <= pixel_address_d;
      frames_seen_q   <= frames_seen_d;
      if (s1_load) begin
        s1_vld_q <= accept;
      end
      if (en) begin
        s2_vld_q    <= s1_vld_q && !hold;
        s3_vld_q    <= s2_vld_q;
        out_valid_q <= s3_vld_q && s3_active_q;
      end
      if (mem_we) begin
        lw_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_active_q <= s0_active;
      s1_pix_q    <= in_data_i.pixel;
      s1_fend_q   <= in_data_i.frame_end;
      s1_addr_q   <= pixel_address_q;
    end
    if (en) begin
      s2_active_q <= s1_active_q;
      s2_pix_q    <= s1_pix_q;
      s2_fend_q   <= s1_fend_q;
      s2_addr_q   <= s1_addr_q;
      s2_old_q    <= s1_old;
      s2_delta_q  <= s1_delta;

      s3_active_q <= s2_active_q;
      s3_pix_q    <= s2_pix_q;
      s3_fend_q   <= s2_fend_q;
      s3_addr_q   <= s2_addr_q;
      s3_old_q    <= s2_old_q;
      s3_step_q   <= s2_prod[WEIGHT_W +: PIX_W];

      out_data_q.foreground    <= (s3_diff > threshold_q);
      out_data_q.difference    <= s3_diff;
      out_data_q.background    <= s3_bg;
      out_data_q.last_in_frame <= s3_fend_q;
    end
    if (mem_we) begin
      lw_addr_q <= s3_addr_q;
      lw_data_q <= s3_wdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/rabs_checker.sv
// Port-level assertions for the background subtraction block and their bind.
`timescale 1ns / 1ps

module rabs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            psel_i,
  input logic                            penable_i,
  input logic                            pwrite_i,
  input logic [rabs_pkg::CFG_ADDR_W-1:0] paddr_i,
  input logic [rabs_pkg::CFG_DATA_W-1:0] pwdata_i,
  input logic [rabs_pkg::CFG_DATA_W-1:0] prdata_o,
  input logic                            pready_o,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input rabs_pkg::pix_out_t              out_data_o
);
  import rabs_pkg::*;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  // A held result freezes the pipeline, so no new request may be taken.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while the output is stalled");

  // No result is offered in the cycle after reset is sampled active.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result right after reset");

  // A weight write reads back on the next cycle.
  a_weight_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel_i && penable_i && pwrite_i && pready_o &&
     paddr_i[CFG_ADDR_W-1:2] == REG_WEIGHT) ##1 (paddr_i[CFG_ADDR_W-1:2] == REG_WEIGHT)
    |-> prdata_o[WEIGHT_W-1:0] == $past(pwdata_i[WEIGHT_W-1:0]))
    else $error("weight register read back wrong");

endmodule

bind running_average_background_subtract rabs_checker u_rabs_checker (.*);
